// File: rtl/core/unordered_scan_table_top_assert.svh
// assertion macros for the unordered scan table
// used by unordered_scan_table_top; expects a clock and reset in scope
`ifndef UNORDERED_SCAN_TABLE_TOP_ASSERT_SVH
`define UNORDERED_SCAN_TABLE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition that holds at every edge outside reset
`define UST_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define UST_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define UST_ASSERT_ALWAYS(lbl, cond, msg)
`define UST_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/core/ust_pkg.sv
// shared constants and codes for the unordered scan table
// no dependencies
`default_nettype none

package ust_pkg;

   localparam int CAPACITY   = 64;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int ADDR_BITS  = $clog2(CAPACITY);
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   // port widths fixed by the word format
   localparam int FUNC_W   = 2;
   localparam int KEY_W    = 32;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = 7;

   // operation codes; the unused code behaves as find
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [COUNT_BITS-1:0] count_type;

endpackage

`default_nettype wire

// File: rtl/core/ust_channel_if.sv
// valid/ready channels for request and response words
// depends on ust_pkg for field widths
`default_nettype none

interface ust_req_if;
   logic                        valid;
   logic                        ready;
   logic [ust_pkg::FUNC_W-1:0]  func;
   logic [ust_pkg::KEY_W-1:0]   key_in;
   logic [ust_pkg::VALUE_W-1:0] value_in;

   modport source (output valid, output func, output key_in, output value_in, input ready);
   modport sink (input valid, input func, input key_in, input value_in, output ready);
endinterface

interface ust_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ust_pkg::STATUS_W-1:0] status;
   logic [ust_pkg::VALUE_W-1:0]  value_out;
   logic [ust_pkg::ENTRY_W-1:0]  entry_count;

   modport source (output valid, output status, output value_out, output entry_count,
                   input ready);
   modport sink (input valid, input status, input value_out, input entry_count,
                 output ready);
endinterface

`default_nettype wire

// File: rtl/core/unordered_scan_table_top.sv
// unordered key/value table with linear scan, single sequencer
// depends on ust_pkg, ust_channel_if.sv and unordered_scan_table_top_assert.svh
//
// usage:
//   req_if carries one request word (func, key_in, value_in); it is taken
//   when valid and ready are both high. func selects insert, delete or find
//   (the spare code acts as find). rsp_if returns one word per request with
//   status, value_out and entry_count after the operation.
//   timing: one request at a time. the scan reads one stored entry per cycle
//   through a single registered memory port and one key comparator, and
//   stops at the first hit or after the last stored entry; a delete then
//   reads and rewrites the last entry through the same port before the
//   response turns valid. with an always-ready receiver the block returns
//   to idle once the response is delivered and takes the next request there.
//   a stalled receiver holds the response word steady in its output register
//   and the block takes no new request until it is delivered.
//   reset clears the entry count and the sequencer; stored entries need no
//   clearing since only slots below the count are ever read.
`default_nettype none

`include "unordered_scan_table_top_assert.svh"

module unordered_scan_table_top (
   input wire logic clock,
   input wire logic reset,
   ust_req_if.sink   req_if,
   ust_rsp_if.source rsp_if
);

   typedef enum logic [4:0] {
      S_IDLE       = 5'b00001,
      S_SCAN       = 5'b00010,
      S_MOVE_READ  = 5'b00100,
      S_MOVE_WRITE = 5'b01000,
      S_RESP       = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   ust_pkg::count_type count_ff, count_in;
   ust_pkg::count_type issue_ff, issue_in;
   logic               chk_valid_ff, chk_valid_in;
   ust_pkg::addr_type  chk_idx_ff, chk_idx_in;
   ust_pkg::addr_type  slot_ff, slot_in;

   logic [ust_pkg::FUNC_W-1:0]   op_ff, op_in;
   ust_pkg::key_type             key_ff, key_in;
   ust_pkg::value_type           val_ff, val_in;
   logic [ust_pkg::STATUS_W-1:0] status_ff, status_in;
   ust_pkg::value_type           out_val_ff, out_val_in;

   // entry storage, one read and one write port
   ust_pkg::key_type   key_mem [ust_pkg::CAPACITY];
   ust_pkg::value_type val_mem [ust_pkg::CAPACITY];
   ust_pkg::key_type   rd_key_ff;
   ust_pkg::value_type rd_val_ff;

   ust_pkg::addr_type  rd_addr;
   logic               wr_en;
   ust_pkg::addr_type  wr_addr;
   ust_pkg::key_type   wr_key;
   ust_pkg::value_type wr_val;

   logic               hit;
   logic               scan_done;
   ust_pkg::count_type last_count;

   assign hit        = chk_valid_ff && (rd_key_ff == key_ff);
   assign scan_done  = hit || (!chk_valid_ff && (issue_ff >= count_ff));
   assign last_count = count_ff - ust_pkg::COUNT_BITS'(1);

   // memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         val_mem[wr_addr] <= wr_val;
      end
      rd_key_ff <= key_mem[rd_addr];
      rd_val_ff <= val_mem[rd_addr];
   end

   // sequencer and shared comparator decisions
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      slot_in      = slot_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      status_in    = status_ff;
      out_val_in   = out_val_ff;
      rd_addr      = issue_ff[ust_pkg::ADDR_BITS-1:0];
      wr_en        = 1'b0;
      wr_addr      = count_ff[ust_pkg::ADDR_BITS-1:0];
      wr_key       = key_ff;
      wr_val       = val_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               op_in    = req_if.func;
               key_in   = req_if.key_in[ust_pkg::KEY_BITS-1:0];
               val_in   = req_if.value_in[ust_pkg::VALUE_BITS-1:0];
               issue_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               status_in  = ust_pkg::ST_OK;
               out_val_in = '0;
               state_in   = S_RESP;
               case (op_ff)
                  ust_pkg::FUNC_INSERT: begin
                     if (hit) begin
                        status_in = ust_pkg::ST_DUP;
                     end else if (count_ff == ust_pkg::COUNT_BITS'(ust_pkg::CAPACITY)) begin
                        status_in = ust_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + ust_pkg::COUNT_BITS'(1);
                     end
                  end
                  ust_pkg::FUNC_DELETE: begin
                     if (hit) begin
                        slot_in  = chk_idx_ff;
                        state_in = S_MOVE_READ;
                     end else begin
                        status_in = ust_pkg::ST_MISS;
                     end
                  end
                  default: begin
                     if (hit) begin
                        out_val_in = rd_val_ff;
                     end else begin
                        status_in = ust_pkg::ST_MISS;
                     end
                  end
               endcase
            end else if (issue_ff < count_ff) begin
               // issue next slot; its key is compared in the next cycle
               chk_valid_in = 1'b1;
               chk_idx_in   = issue_ff[ust_pkg::ADDR_BITS-1:0];
               issue_in     = issue_ff + ust_pkg::COUNT_BITS'(1);
            end
         end
         S_MOVE_READ: begin
            rd_addr  = last_count[ust_pkg::ADDR_BITS-1:0];
            state_in = S_MOVE_WRITE;
         end
         S_MOVE_WRITE: begin
            // last entry fills the freed slot
            wr_en    = 1'b1;
            wr_addr  = slot_ff;
            wr_key   = rd_key_ff;
            wr_val   = rd_val_ff;
            count_in = last_count;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_if.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   // working and output word registers
   always_ff @(posedge clock) begin
      issue_ff   <= issue_in;
      chk_idx_ff <= chk_idx_in;
      slot_ff    <= slot_in;
      op_ff      <= op_in;
      key_ff     <= key_in;
      val_ff     <= val_in;
      status_ff  <= status_in;
      out_val_ff <= out_val_in;
   end

   // channel outputs
   assign req_if.ready       = (state_ff == S_IDLE);
   assign rsp_if.valid       = (state_ff == S_RESP);
   assign rsp_if.status      = status_ff;
   assign rsp_if.value_out   = ust_pkg::VALUE_W'(out_val_ff);
   assign rsp_if.entry_count = ust_pkg::ENTRY_W'(count_ff);

   // checks
   `UST_ASSERT_ALWAYS(a_count_bound,
      count_ff <= ust_pkg::COUNT_BITS'(ust_pkg::CAPACITY), "entry count above capacity")
   `UST_ASSERT_ALWAYS(a_one_side,
      !(req_if.ready && rsp_if.valid), "request taken while response pending")
   `UST_ASSERT_NEXT(a_accept_scan, req_if.valid && req_if.ready,
      state_ff == S_SCAN, "accepted word did not start a scan")
   `UST_ASSERT_NEXT(a_move_count, state_ff == S_MOVE_WRITE,
      (count_ff == $past(count_ff) - ust_pkg::COUNT_BITS'(1)) && rsp_if.valid,
      "delete did not shrink the table")

endmodule

`default_nettype wire
